// ----- rtl/core/nmgll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_pkg: shared types, constants and tables of the GLL sentence parser
// Character codes, coordinate window weights and the structs that run
// between the line framer, the coordinate accumulators and the result stage.
// ----------------------------------------------------------------------------
package nmgll_pkg;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // header tracking: 0..5 bytes matched, then matched or missed
  localparam logic [2:0] HDR_MATCHED = 3'd6;
  localparam logic [2:0] HDR_MISS    = 3'd7;

  // coordinate window: slot 0 is the skip slot, slots 1..28 are offsets 0..27
  localparam logic [4:0] WIN_END   = 5'd29;
  localparam logic [4:0] OFF_SOUTH = 5'd12;
  localparam logic [4:0] OFF_WEST  = 5'd27;

  // accumulator widths
  localparam int ACC_W = 39;
  localparam int Q_W   = 30;
  localparam int D_W   = 9;

  // clamp limits in degrees times 10^7
  localparam logic signed [39:0] LAT_LIM = 40'sd1000000000;
  localparam logic signed [39:0] LON_LIM = 40'sd10000000000;

  typedef enum logic [1:0] {
    FIX_UNDEC   = 2'd0,
    FIX_DECODE  = 2'd1,
    FIX_INVALID = 2'd2,
    FIX_NONE    = 2'd3
  } fix_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CKSUM   = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOFIX   = 2'd3
  } status_e;

  // weight of one window offset: k is the full e7 weight of the digit,
  // wq and wr split the micro-minute weight into quotient and remainder by 6
  typedef struct packed {
    logic               lat;
    logic               lon;
    logic signed [30:0] k;
    logic signed [21:0] wq;
    logic [2:0]         wr;
  } weight_t;

  // one window update toward the coordinate accumulators
  typedef struct packed {
    logic                  lat_en;
    logic                  lon_en;
    logic signed [D_W-1:0] d;
    weight_t               wt;
  } win_t;

  // accumulator state: acc = degrees*10^7 + floor(micro/6), micro = 6*q + r
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [Q_W-1:0]   q;
    logic [2:0]              r;
  } coord_t;

  // line close information from the framer
  typedef struct packed {
    logic    hit;
    status_e status;
    logic    south;
    logic    west;
  } frm_res_t;

  // expected header byte at a header position
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h4C;
      3'd5:    c = 8'h4C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // weight table of the coordinate window
  function automatic weight_t coord_weight(input logic [4:0] off);
    weight_t w;
    w = '0;
    unique case (off)
      5'd0:  begin w.lat = 1'b1; w.k = 31'sd100000000; end
      5'd1:  begin w.lat = 1'b1; w.k = 31'sd10000000; end
      5'd2:  begin w.lat = 1'b1; w.k = 31'sd1666666; w.wq = 22'sd1666666; w.wr = 3'd4; end
      5'd3:  begin w.lat = 1'b1; w.k = 31'sd166666; w.wq = 22'sd166666; w.wr = 3'd4; end
      5'd5:  begin w.lat = 1'b1; w.k = 31'sd16666; w.wq = 22'sd16666; w.wr = 3'd4; end
      5'd6:  begin w.lat = 1'b1; w.k = 31'sd1666; w.wq = 22'sd1666; w.wr = 3'd4; end
      5'd7:  begin w.lat = 1'b1; w.k = 31'sd166; w.wq = 22'sd166; w.wr = 3'd4; end
      5'd8:  begin w.lat = 1'b1; w.k = 31'sd16; w.wq = 22'sd16; w.wr = 3'd4; end
      5'd9:  begin w.lat = 1'b1; w.k = 31'sd1; w.wq = 22'sd1; w.wr = 3'd4; end
      5'd10: begin w.lat = 1'b1; w.wr = 3'd1; end
      5'd14: begin w.lon = 1'b1; w.k = 31'sd1000000000; end
      5'd15: begin w.lon = 1'b1; w.k = 31'sd100000000; end
      5'd16: begin w.lon = 1'b1; w.k = 31'sd10000000; end
      5'd17: begin w.lon = 1'b1; w.k = 31'sd1666666; w.wq = 22'sd1666666; w.wr = 3'd4; end
      5'd18: begin w.lon = 1'b1; w.k = 31'sd166666; w.wq = 22'sd166666; w.wr = 3'd4; end
      5'd20: begin w.lon = 1'b1; w.k = 31'sd16666; w.wq = 22'sd16666; w.wr = 3'd4; end
      5'd21: begin w.lon = 1'b1; w.k = 31'sd1666; w.wq = 22'sd1666; w.wr = 3'd4; end
      5'd22: begin w.lon = 1'b1; w.k = 31'sd166; w.wq = 22'sd166; w.wr = 3'd4; end
      5'd23: begin w.lon = 1'b1; w.k = 31'sd16; w.wq = 22'sd16; w.wr = 3'd4; end
      5'd24: begin w.lon = 1'b1; w.k = 31'sd1; w.wq = 22'sd1; w.wr = 3'd4; end
      5'd25: begin w.lon = 1'b1; w.wr = 3'd1; end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/nmgll_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_byte_if: byte stream channel
// Valid/ready channel that carries one character of the NMEA stream.
// ----------------------------------------------------------------------------
interface nmgll_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- rtl/core/nmgll_fix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_fix_if: position result channel
// Valid/ready channel that carries one parsed GLL status and position.
// ----------------------------------------------------------------------------
interface nmgll_fix_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [30:0] latitude_e7;
  logic signed [34:0] longitude_e7;

  modport source (output valid, output status, output latitude_e7, output longitude_e7,
                  input ready);
  modport sink   (input valid, input status, input latitude_e7, input longitude_e7,
                  output ready);
endinterface

// ----- rtl/core/nmea_gll_sentence_parser_core.sv -----
`timescale 1ns / 1ps
// Result path: the result of a newline byte goes from the input register to
// the output register, from which it is offered. Throughput: one byte per
// cycle; the input stalls only while a result waits in the output register
// and the input register holds the newline of a GNGLL line with a star.
// Reset: asynchronous, active low; the parser starts at the head of a line
// and both registers are empty.
// ----------------------------------------------------------------------------
// nmea_gll_sentence_parser_core: GNGLL sentence parser
// Parses an NMEA byte stream and gives status and position of every
// GNGLL line that carries a checksum star.
// ----------------------------------------------------------------------------
module nmea_gll_sentence_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  nmgll_byte_if.sink byte_i,
  nmgll_fix_if.source fix_o
);

  logic                s1_vld_q;
  logic [7:0]          s1_byte_q;
  logic                s1_adv;
  logic                out_free;
  logic                out_vld;
  nmgll_pkg::frm_res_t frm_res;
  nmgll_pkg::win_t     win;
  logic                clr;
  nmgll_pkg::coord_t   lat_c;
  nmgll_pkg::coord_t   lon_c;

  // handshake between the input register and the output register
  assign out_free     = !out_vld || fix_o.ready;
  assign s1_adv       = s1_vld_q && (!frm_res.hit || out_free);
  assign byte_i.ready = !s1_vld_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_byte_q <= byte_i.data_byte;
    end
  end

  // line framer
  nmgll_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .res_o  (frm_res),
    .win_o  (win),
    .clr_o  (clr)
  );

  // latitude and longitude accumulators
  nmgll_coord u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .en_i    (win.lat_en),
    .win_i   (win),
    .coord_o (lat_c)
  );

  nmgll_coord u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .en_i    (win.lon_en),
    .win_i   (win),
    .coord_o (lon_c)
  );

  // result stage
  nmgll_result u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_adv && frm_res.hit),
    .pop_i    (fix_o.ready),
    .frm_i    (frm_res),
    .lat_i    (lat_c),
    .lon_i    (lon_c),
    .valid_o  (out_vld),
    .status_o (fix_o.status),
    .lat_o    (fix_o.latitude_e7),
    .lon_o    (fix_o.longitude_e7)
  );

  assign fix_o.valid = out_vld;

endmodule

// ----- rtl/core/nmgll_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_frame: line framer
// Tracks the header, the running checksum, the sent checksum, the fix flag
// and the coordinate window position of the current line.
// ----------------------------------------------------------------------------
module nmgll_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output nmgll_pkg::frm_res_t res_o,
  output nmgll_pkg::win_t     win_o,
  output logic                clr_o
);

  logic [2:0]       hdr_q, hdr_d;
  logic             star_q, star_d;
  logic [7:0]       xor_q, xor_d;
  logic [1:0]       hex_cnt_q, hex_cnt_d;
  logic [7:0]       cs_q, cs_d;
  logic             comma_q, comma_d;
  nmgll_pkg::fix_e  fix_q, fix_d;
  logic [4:0]       pos_q, pos_d;
  logic             south_q, south_d;
  logic             west_q, west_d;

  logic             is_nl;
  logic [7:0]       cs_digit;
  logic             feed;
  logic [4:0]       feed_pos;
  logic [4:0]       win_off;
  logic             win_act;
  nmgll_pkg::weight_t wt;

  assign is_nl    = (byte_i == nmgll_pkg::CH_NL);
  assign cs_digit = (byte_i > nmgll_pkg::CH_NINE) ? byte_i - nmgll_pkg::CH_SEVEN
                                                 : byte_i - nmgll_pkg::CH_ZERO;
  assign win_off  = feed_pos - 5'd1;
  assign win_act  = feed && (feed_pos != 5'd0);
  assign wt       = nmgll_pkg::coord_weight(win_off);

  // next state of the line
  always_comb begin
    hdr_d     = hdr_q;
    star_d    = star_q;
    xor_d     = xor_q;
    hex_cnt_d = hex_cnt_q;
    cs_d      = cs_q;
    comma_d   = comma_q;
    fix_d     = fix_q;
    pos_d     = pos_q;
    south_d   = south_q;
    west_d    = west_q;
    feed      = 1'b0;
    feed_pos  = pos_q;
    if (is_nl) begin
      hdr_d     = '0;
      star_d    = 1'b0;
      xor_d     = '0;
      hex_cnt_d = '0;
      cs_d      = '0;
      comma_d   = 1'b0;
      fix_d     = nmgll_pkg::FIX_UNDEC;
      pos_d     = '0;
      south_d   = 1'b0;
      west_d    = 1'b0;
    end else begin
      // header match
      if (hdr_q < nmgll_pkg::HDR_MATCHED) begin
        hdr_d = (byte_i == nmgll_pkg::hdr_char(hdr_q)) ? hdr_q + 3'd1 : nmgll_pkg::HDR_MISS;
      end
      // running checksum and sent checksum digits
      if (!star_q) begin
        if (byte_i == nmgll_pkg::CH_STAR) begin
          star_d = 1'b1;
        end else if (byte_i != nmgll_pkg::CH_DOLLAR) begin
          xor_d = xor_q ^ byte_i;
        end
      end else if (hex_cnt_q < 2'd2) begin
        if (hex_cnt_q == 2'd0) begin
          cs_d = {cs_digit[3:0], 4'h0};
        end else begin
          cs_d = cs_q | cs_digit;
        end
        hex_cnt_d = hex_cnt_q + 2'd1;
      end
      // fix flag and coordinate window
      if (!comma_q) begin
        if (byte_i == nmgll_pkg::CH_COMMA) begin
          comma_d = 1'b1;
        end
      end else begin
        unique case (fix_q)
          nmgll_pkg::FIX_UNDEC: begin
            if (byte_i == nmgll_pkg::CH_A) begin
              fix_d = nmgll_pkg::FIX_DECODE;
              pos_d = '0;
            end else if (byte_i == nmgll_pkg::CH_V) begin
              fix_d = nmgll_pkg::FIX_INVALID;
            end else if (byte_i == nmgll_pkg::CH_COMMA) begin
              fix_d = nmgll_pkg::FIX_NONE;
            end else begin
              fix_d    = nmgll_pkg::FIX_DECODE;
              feed     = 1'b1;
              feed_pos = 5'd1;
            end
          end
          nmgll_pkg::FIX_DECODE: begin
            feed = (pos_q < nmgll_pkg::WIN_END);
          end
          default: ;
        endcase
      end
      // hemisphere marks, window slot is the offset plus one
      if (feed) begin
        pos_d = feed_pos + 5'd1;
        if (feed_pos == (nmgll_pkg::OFF_SOUTH + 5'd1)) begin
          south_d = (byte_i == nmgll_pkg::CH_S);
        end
        if (feed_pos == (nmgll_pkg::OFF_WEST + 5'd1)) begin
          west_d = (byte_i == nmgll_pkg::CH_W);
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= '0;
      star_q    <= 1'b0;
      xor_q     <= '0;
      hex_cnt_q <= '0;
      cs_q      <= '0;
      comma_q   <= 1'b0;
      fix_q     <= nmgll_pkg::FIX_UNDEC;
      pos_q     <= '0;
      south_q   <= 1'b0;
      west_q    <= 1'b0;
    end else if (step_i) begin
      hdr_q     <= hdr_d;
      star_q    <= star_d;
      xor_q     <= xor_d;
      hex_cnt_q <= hex_cnt_d;
      cs_q      <= cs_d;
      comma_q   <= comma_d;
      fix_q     <= fix_d;
      pos_q     <= pos_d;
      south_q   <= south_d;
      west_q    <= west_d;
    end
  end

  // line close status, checksum first, then invalid flag, then no fix
  always_comb begin
    res_o.hit   = is_nl && (hdr_q == nmgll_pkg::HDR_MATCHED) && star_q;
    res_o.south = south_q;
    res_o.west  = west_q;
    if (xor_q != cs_q) begin
      res_o.status = nmgll_pkg::ST_CKSUM;
    end else if (fix_q == nmgll_pkg::FIX_INVALID) begin
      res_o.status = nmgll_pkg::ST_INVALID;
    end else if (fix_q != nmgll_pkg::FIX_DECODE) begin
      res_o.status = nmgll_pkg::ST_NOFIX;
    end else begin
      res_o.status = nmgll_pkg::ST_OK;
    end
  end

  // window update toward the accumulators
  assign win_o.lat_en = step_i && !is_nl && win_act && wt.lat;
  assign win_o.lon_en = step_i && !is_nl && win_act && wt.lon;
  assign win_o.d      = $signed({1'b0, byte_i}) - 9'sd48;
  assign win_o.wt     = wt;
  assign clr_o        = step_i && is_nl;

endmodule

// ----- rtl/core/nmgll_coord.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_coord: coordinate accumulator
// Accumulates one axis in degrees times 10^7, keeping the micro-minute sum
// as quotient and remainder by six so that no divider is needed.
// ----------------------------------------------------------------------------
module nmgll_coord (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              en_i,
  input  nmgll_pkg::win_t   win_i,
  output nmgll_pkg::coord_t coord_o
);

  nmgll_pkg::coord_t c_q, c_d;

  logic signed [39:0] prod_k;
  logic signed [29:0] prod_q;
  logic signed [11:0] prod_r;
  logic signed [11:0] t_s;
  logic [10:0]        t;
  logic [21:0]        t_mul;
  logic [9:0]         qd;
  logic [10:0]        six_q;
  logic [10:0]        rem;
  logic signed [10:0] qd_off;

  // digit times weight
  assign prod_k = 40'(win_i.d) * 40'(win_i.wt.k);
  assign prod_q = 30'(win_i.d) * 30'(win_i.wt.wq);
  assign prod_r = 12'(win_i.d) * $signed({9'b0, win_i.wt.wr});

  // new remainder, offset by 192 to stay positive, split by six
  assign t_s    = $signed({9'b0, c_q.r}) + prod_r + 12'sd192;
  assign t      = t_s[10:0];
  assign t_mul  = 22'(t) * 22'd683;
  assign qd     = t_mul[21:12];
  assign six_q  = 11'(qd) * 11'd6;
  assign rem    = t - six_q;
  assign qd_off = $signed({1'b0, qd}) - 11'sd32;

  assign c_d.acc = c_q.acc + 39'(prod_k) + 39'(qd_off);
  assign c_d.q   = c_q.q + prod_q + 30'(qd_off);
  assign c_d.r   = rem[2:0];

  // accumulator registers, cleared at line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (clr_i) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end

  assign coord_o = c_q;

endmodule

// ----- rtl/core/nmgll_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_result: result stage
// Turns the accumulators into signed, clamped coordinates (zero unless the
// line is ok) and holds the result item in the output register until it is taken.
// ----------------------------------------------------------------------------
module nmgll_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                pop_i,
  input  nmgll_pkg::frm_res_t frm_i,
  input  nmgll_pkg::coord_t   lat_i,
  input  nmgll_pkg::coord_t   lon_i,
  output logic                valid_o,
  output logic [1:0]          status_o,
  output logic signed [30:0]  lat_o,
  output logic signed [34:0]  lon_o
);

  // truncate toward zero, apply hemisphere, clamp
  function automatic logic signed [39:0] coord_final(input nmgll_pkg::coord_t c,
                                                    input logic neg,
                                                    input logic signed [39:0] lim);
    logic signed [39:0] v;
    v = 40'(c.acc) + (((c.q < 0) && (c.r != 3'd0)) ? 40'sd1 : 40'sd0);
    if (neg) begin
      v = -v;
    end
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v;
  endfunction

  logic                   vld_q;
  nmgll_pkg::status_e     stat_q;
  logic signed [30:0]     lat_q;
  logic signed [34:0]     lon_q;
  logic signed [39:0]     lat_v;
  logic signed [39:0]     lon_v;
  logic                   ok;

  assign ok    = (frm_i.status == nmgll_pkg::ST_OK);
  assign lat_v = coord_final(lat_i, frm_i.south, nmgll_pkg::LAT_LIM);
  assign lon_v = coord_final(lon_i, frm_i.west, nmgll_pkg::LON_LIM);

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (pop_i) begin
      vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stat_q <= frm_i.status;
      lat_q  <= ok ? lat_v[30:0] : '0;
      lon_q  <= ok ? lon_v[34:0] : '0;
    end
  end

  assign valid_o  = vld_q;
  assign status_o = stat_q;
  assign lat_o    = lat_q;
  assign lon_o    = lon_q;

endmodule

// ----- rtl/core/nmgll_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmgll_checker: result port checks
// Watches the result channel of the parser and checks the handshake, the
// zero coordinates of failed lines and the coordinate ranges.
// ----------------------------------------------------------------------------
module nmgll_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         status_i,
  input logic signed [30:0] lat_i,
  input logic signed [34:0] lon_i
);

  // a waiting item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // a waiting item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(lat_i) && $stable(lon_i))
    else $error("result payload changed while stalled");

  // coordinates are zero unless the line is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != nmgll_pkg::ST_OK) |-> (lat_i == '0) && (lon_i == '0))
    else $error("nonzero coordinates on a failed line");

  // latitude is clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lat_i <= 31'sd1000000000) && (lat_i >= -31'sd1000000000))
    else $error("latitude out of range");

  // longitude is clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lon_i <= 35'sd10000000000) && (lon_i >= -35'sd10000000000))
    else $error("longitude out of range");

endmodule

bind nmea_gll_sentence_parser_core nmgll_checker u_nmgll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (fix_o.valid),
  .out_ready_i (fix_o.ready),
  .status_i    (fix_o.status),
  .lat_i       (fix_o.latitude_e7),
  .lon_i       (fix_o.longitude_e7)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: GNGLL sentence parser testbench
// Streams NMEA lines into the parser byte by byte: a few hand-made lines for
// the corner cases, then random sentences, broken lines and raw noise under
// changing source and sink gaps. A line-level model in the scoreboard class
// predicts every status and position item and checks each one on arrival.
// ----------------------------------------------------------------------------
module tb;
  import nmgll_pkg::*;

  localparam logic [47:0]     GLL_HEAD  = "$GNGLL";
  localparam longint          E7        = 64'sd10000000;
  localparam longint          LAT_BOUND = 64'sd1000000000;
  localparam longint          LON_BOUND = 64'sd10000000000;
  localparam int unsigned     HOLD_LEN  = 400;

  typedef struct {
    status_e            status;
    logic signed [30:0] lat;
    logic signed [34:0] lon;
  } fix_t;

  typedef enum int {
    LK_OK, LK_BAD_SUM, LK_INVALID, LK_NOFIX, LK_NO_STAR, LK_BAD_HEAD, LK_SHORT, LK_NOISE
  } line_kind_e;

  // line parser model and store of expected fix items
  class gll_fix_scoreboard;
    logic [2:0]  hdr_pos;
    bit          star_seen;
    logic [7:0]  xor_sum;
    int unsigned hex_cnt;
    logic [7:0]  sent_sum;
    bit          comma_seen;
    fix_e        fix;
    int unsigned win_pos;
    longint      lat_deg, lat_micro, lon_deg, lon_micro;
    bit          south, west;
    fix_t        fix_q[$];
    int unsigned fixes_expected;
    int unsigned error_count;

    function new();
      clear_line();
      fixes_expected = 0;
      error_count = 0;
    endfunction

    function void clear_line();
      hdr_pos = '0;
      star_seen = 1'b0;
      xor_sum = '0;
      hex_cnt = 0;
      sent_sum = '0;
      comma_seen = 1'b0;
      fix = FIX_UNDEC;
      win_pos = 0;
      lat_deg = 0;
      lat_micro = 0;
      lon_deg = 0;
      lon_micro = 0;
      south = 1'b0;
      west = 1'b0;
    endfunction

    // micro-minute weight of a minutes offset, the decimal point weighs nothing
    function longint minute_weight(input int unsigned idx);
      case (idx)
        0:       return 10000000;
        1:       return 1000000;
        3:       return 100000;
        4:       return 10000;
        5:       return 1000;
        6:       return 100;
        7:       return 10;
        8:       return 1;
        default: return 0;
      endcase
    endfunction

    function longint clamp_abs(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // one byte of the fixed coordinate window
    function void feed_window(input logic [7:0] b);
      longint      d;
      int unsigned p;
      d = longint'(b) - 64'sd48;
      if (win_pos >= WIN_END) return;
      if (win_pos >= 1) begin
        p = win_pos - 1;
        if (p == 0) lat_deg = d * 10;
        else if (p == 1) lat_deg += d;
        else if (p >= 2 && p <= 10) lat_micro += d * minute_weight(p - 2);
        else if (p == 12) south = (b == CH_S);
        else if (p == 14) lon_deg = d * 100;
        else if (p == 15) lon_deg += d * 10;
        else if (p == 16) lon_deg += d;
        else if (p >= 17 && p <= 25) lon_micro += d * minute_weight(p - 17);
        else if (p == 27) west = (b == CH_W);
      end
      win_pos++;
    endfunction

    // close a line: a matched header with a star gives one fix item
    function void close_line();
      fix_t   r;
      longint lat, lon;
      if (hdr_pos == HDR_MATCHED && star_seen) begin
        r.lat = '0;
        r.lon = '0;
        if (xor_sum != sent_sum) r.status = ST_CKSUM;
        else if (fix == FIX_INVALID) r.status = ST_INVALID;
        else if (fix != FIX_DECODE) r.status = ST_NOFIX;
        else begin
          r.status = ST_OK;
          lat = lat_deg * E7 + lat_micro / 6;
          lon = lon_deg * E7 + lon_micro / 6;
          if (south) lat = -lat;
          if (west) lon = -lon;
          lat = clamp_abs(lat, LAT_BOUND);
          lon = clamp_abs(lon, LON_BOUND);
          r.lat = lat[30:0];
          r.lon = lon[34:0];
        end
        fix_q.push_back(r);
        fixes_expected++;
      end
      clear_line();
    endfunction

    // accepted input byte
    function void note_byte(input logic [7:0] b);
      logic [7:0] dig;
      if (b == CH_NL) begin
        close_line();
        return;
      end
      // header match
      if (hdr_pos < HDR_MATCHED)
        hdr_pos = (b == GLL_HEAD[47 - 8 * hdr_pos -: 8]) ? hdr_pos + 3'd1 : HDR_MISS;
      // running checksum and the two sent digits
      if (!star_seen) begin
        if (b == CH_STAR) star_seen = 1'b1;
        else if (b != CH_DOLLAR) xor_sum ^= b;
      end else if (hex_cnt < 2) begin
        dig = (b > CH_NINE) ? b - CH_SEVEN : b - CH_ZERO;
        if (hex_cnt == 0) sent_sum = {dig[3:0], 4'h0};
        else sent_sum = sent_sum | dig;
        hex_cnt++;
      end
      // field one and the coordinate window
      if (!comma_seen) begin
        if (b == CH_COMMA) comma_seen = 1'b1;
      end else if (fix == FIX_UNDEC) begin
        if (b == CH_A) begin
          fix = FIX_DECODE;
          win_pos = 0;
        end else if (b == CH_V) fix = FIX_INVALID;
        else if (b == CH_COMMA) fix = FIX_NONE;
        else begin
          fix = FIX_DECODE;
          win_pos = 1;
          feed_window(b);
        end
      end else if (fix == FIX_DECODE) begin
        feed_window(b);
      end
    endfunction

    // compare one output item with the oldest expectation
    function void check_fix(input logic [1:0] st, input logic signed [30:0] lat,
                            input logic signed [34:0] lon);
      fix_t e;
      if (fix_q.size() == 0) begin
        $error("unexpected fix item: status %0d, latitude_e7 %0d, longitude_e7 %0d",
               st, lat, lon);
        error_count++;
        return;
      end
      e = fix_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        error_count++;
      end
      if (lat !== e.lat) begin
        $error("latitude_e7: expected %0d, got %0d", e.lat, lat);
        error_count++;
      end
      if (lon !== e.lon) begin
        $error("longitude_e7: expected %0d, got %0d", e.lon, lon);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return fix_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nmgll_byte_if byte_if ();
  nmgll_fix_if  fix_if ();

  nmea_gll_sentence_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .fix_o  (fix_if)
  );

  gll_fix_scoreboard sb = new();

  logic [7:0]  line_buf[$];
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // sink side: random stalls and the long hold-off
  initial begin
    fix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        fix_if.ready <= 1'b0;
      end else begin
        fix_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && fix_if.valid && fix_if.ready)
      sb.check_fix(fix_if.status, fix_if.latitude_e7, fix_if.longitude_e7);
  end

  // offer one byte with random gaps, note it once accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  // drop valid and wait for every expected item
  task automatic wait_drained();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_A + 8'(v) - 8'd10;
  endfunction

  // append star and checksum digits (when with_star), then newline
  function automatic void close_text(input bit with_star, input bit good_sum);
    logic [7:0] sum;
    bit         hit;
    sum = '0;
    hit = 1'b0;
    foreach (line_buf[i]) begin
      if (!hit) begin
        if (line_buf[i] == CH_STAR) hit = 1'b1;
        else if (line_buf[i] != CH_DOLLAR) sum ^= line_buf[i];
      end
    end
    if (with_star) begin
      line_buf.push_back(CH_STAR);
      if (good_sum) begin
        line_buf.push_back(hex_char(sum[7:4]));
        line_buf.push_back(hex_char(sum[3:0]));
      end else if ($urandom_range(1)) begin
        sum ^= 8'($urandom_range(1, 255));
        line_buf.push_back(hex_char(sum[7:4]));
        line_buf.push_back(hex_char(sum[3:0]));
      end else begin
        line_buf.push_back(8'($urandom_range(11, 255)));
        line_buf.push_back(8'($urandom_range(11, 255)));
      end
    end
    line_buf.push_back(CH_NL);
  endfunction

  // window digit: all nines, all zeros, or mostly digits with stray bytes
  function automatic logic [7:0] coord_char(input int unsigned mode);
    if (mode == 0) return CH_NINE;
    if (mode == 1) return CH_ZERO;
    if ($urandom_range(99) < 8) return 8'($urandom_range(11, 255));
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic void push_hemi(input string plain, input string flip);
    if ($urandom_range(19) == 0) line_buf.push_back(8'($urandom_range(11, 255)));
    else push_text($urandom_range(1) ? flip : plain);
  endfunction

  // DDMM.mmmmmm,N,DDDMM.mmmmmm,E
  function automatic void push_coords();
    int unsigned mode;
    mode = $urandom_range(9);
    repeat (4) line_buf.push_back(coord_char(mode));
    push_text(".");
    repeat (6) line_buf.push_back(coord_char(mode));
    push_text(",");
    push_hemi("N", "S");
    push_text(",");
    repeat (5) line_buf.push_back(coord_char(mode));
    push_text(".");
    repeat (6) line_buf.push_back(coord_char(mode));
    push_text(",");
    push_hemi("E", "W");
  endfunction

  function automatic void build_line(input line_kind_e kind);
    int unsigned n;
    int unsigned k;
    logic [7:0]  c;
    line_buf.delete();
    if (kind == LK_NOISE) begin
      n = $urandom_range(1, 12);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
      return;
    end
    push_text("$GNGLL,");
    case (kind)
      LK_NOFIX: begin
        push_text(",");
      end
      LK_INVALID: begin
        push_text("V,");
        if ($urandom_range(1)) push_coords();
      end
      default: begin
        if ($urandom_range(1)) push_text("A,");
        push_coords();
      end
    endcase
    if ($urandom_range(1)) push_text(",225444.00,A,A");
    close_text(kind != LK_NO_STAR, kind != LK_BAD_SUM);
    // break one header byte
    if (kind == LK_BAD_HEAD) begin
      k = $urandom_range(5);
      c = 8'($urandom_range(11, 255));
      if (c == line_buf[k]) c ^= 8'h01;
      line_buf[k] = c;
    end
    // cut the line anywhere
    if (kind == LK_SHORT) begin
      n = $urandom_range(1, line_buf.size() - 2);
      while (line_buf.size() > n) void'(line_buf.pop_back());
      line_buf.push_back(CH_NL);
    end
  endfunction

  function automatic line_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 52) return LK_OK;
    if (r < 60) return LK_BAD_SUM;
    if (r < 67) return LK_INVALID;
    if (r < 74) return LK_NOFIX;
    if (r < 79) return LK_NO_STAR;
    if (r < 84) return LK_BAD_HEAD;
    if (r < 93) return LK_SHORT;
    return LK_NOISE;
  endfunction

  task automatic send_text(input string s, input bit good_sum);
    line_buf.delete();
    push_text(s);
    close_text(1'b1, good_sum);
    send_line();
  endtask

  task automatic send_raw(input string s);
    line_buf.delete();
    push_text(s);
    line_buf.push_back(CH_NL);
    send_line();
  endtask

  // hand-made corner cases
  task automatic run_directed();
    line_buf.delete();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_NL);
    send_line();
    send_raw("$GNG");                       // header cut short
    send_text("$GNGLL,", 1'b1);             // star right after the first comma enters the window
    send_text("$GNGLL,,", 1'b1);            // empty field one
    send_text("$GNGLL,V", 1'b1);            // invalid flag
    send_text("$GNGLL,V", 1'b0);            // checksum wins over invalid flag
    send_text("$GNGLL,A,1", 1'b1);          // skip after A, short window
    send_raw("$GNGLL,A,5**");               // star taken as a checksum digit
    send_raw("$GNGLL,,*4e");                // lower-case hex digit
    send_text("$GNGLL,9999.999999,S,99999.999999,W", 1'b1);
    send_text("$GNGLL,9999.999999,N,99999.999999,E", 1'b1);
    send_text("$GNGLL,0000.000000,N,00000.000000,E", 1'b1);
    send_text("$GNGLL, !/. ~,S,\x7f#/)!.\x80\xff ,W", 1'b1);
    wait_drained();
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned byte_goal, input int unsigned fix_goal);
    int unsigned b0;
    int unsigned f0;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    b0 = bytes_sent;
    f0 = sb.fixes_expected;
    while (bytes_sent - b0 < byte_goal || sb.fixes_expected - f0 < fix_goal) begin
      build_line(pick_kind());
      send_line();
    end
    wait_drained();
  endtask

  // sink holds off while short lines keep coming, so the input stalls
  task automatic run_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (8) begin
      build_line(LK_NOFIX);
      send_line();
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_phase(0, 0, 360, 6);
    run_phase(77, 0, 360, 6);
    run_backpressure();
    run_phase(0, 77, 360, 6);
    run_phase(10, 10, 360, 6);

    repeat (10) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/nmgll_pkg.sv
rtl/core/nmgll_byte_if.sv
rtl/core/nmgll_fix_if.sv
rtl/core/nmgll_frame.sv
rtl/core/nmgll_coord.sv
rtl/core/nmgll_result.sv
rtl/core/nmea_gll_sentence_parser_core.sv
rtl/core/nmgll_checker.sv
tb/tb.sv
